// ----- hdl/abrl_pkg.sv -----
// Shared types and constants for the address blocklist rate limiter.
package abrl_pkg;

  localparam int MIN_SLOTS     = 5;
  localparam int FIVE_SLOTS    = 12;
  localparam int QUARTER_SLOTS = 3;
  localparam int NUM_SLOTS     = MIN_SLOTS + FIVE_SLOTS;
  localparam int SLOT_IDX_W    = 5;
  localparam int REQ_W         = 3;
  localparam int ADDR_W        = 32;
  localparam int STAT_W        = 4;
  localparam int LIM_W         = 20;
  localparam int SIZE_W        = 7;
  localparam int CFG_IDX_W     = 3;
  localparam logic [LIM_W-1:0] HIT_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_TEST, REQ_ADD, REQ_DEL, REQ_QUERY, REQ_TICK, REQ_RST_ALL, REQ_RST_CNT, REQ_RST_BLK
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK, ST_BAD_ADDR, ST_BLOCKED, ST_LIM1, ST_LIM5, ST_LIM15, ST_LIM60, ST_FULL, ST_DONE
  } stat_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLK_EN, CFG_LIM_EN, CFG_LIM1, CFG_LIM5, CFG_LIM15, CFG_LIM60
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_BSCAN, S_BACT, S_TSCAN, S_TROW, S_TEVAL, S_SUM, S_CHECK,
    S_TICK, S_RESP
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic bad;
    logic clear;
    logic bscan_start;
    logic bscan;
    logic bact;
    logic tscan_start;
    logic tscan;
    logic trow;
    logic teval;
    logic sum;
    logic check;
    logic tick_adv;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    req_e req_type;
    logic bad;
    logic bscan_done;
    logic tscan_done;
    logic counting;
    logic sum_done;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/abrl_if.sv -----
// Request and response channel interfaces.
interface abrl_req_if;
  logic                         valid;
  logic                         ready;
  logic [abrl_pkg::REQ_W-1:0]   req_type;
  logic [abrl_pkg::ADDR_W-1:0]  source_address;
  modport source (output valid, req_type, source_address, input ready);
  modport sink (input valid, req_type, source_address, output ready);
endinterface

interface abrl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         allowed;
  logic [abrl_pkg::STAT_W-1:0]  status;
  logic                         listed;
  logic [abrl_pkg::SIZE_W-1:0]  blocklist_size;
  logic [abrl_pkg::LIM_W-1:0]   hit_count;
  modport source (output valid, allowed, status, listed, blocklist_size, hit_count,
                  input ready);
  modport sink (input valid, allowed, status, listed, blocklist_size, hit_count,
                output ready);
endinterface

// ----- hdl/abrl_ctrl.sv -----
// Request sequencer state machine.
module abrl_ctrl import abrl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (st_i.in_valid) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (st_i.bad) begin
          state_d = S_RESP;
        end else if (st_i.req_type == REQ_TICK) begin
          state_d = S_TICK;
        end else if (st_i.req_type == REQ_RST_ALL || st_i.req_type == REQ_RST_CNT ||
                     st_i.req_type == REQ_RST_BLK) begin
          state_d = S_RESP;
        end else begin
          state_d = S_BSCAN;
        end
      end
      S_BSCAN: begin
        if (st_i.bscan_done) state_d = (st_i.req_type == REQ_TEST) ? S_TSCAN : S_BACT;
      end
      S_BACT:  state_d = S_RESP;
      S_TSCAN: begin
        if (st_i.tscan_done) state_d = (st_i.req_type == REQ_TICK) ? S_RESP : S_TROW;
      end
      S_TROW:  state_d = S_TEVAL;
      S_TEVAL: state_d = st_i.counting ? S_SUM : S_RESP;
      S_SUM: begin
        if (st_i.sum_done) state_d = S_CHECK;
      end
      S_CHECK: state_d = S_RESP;
      S_TICK:  state_d = S_TSCAN;
      S_RESP: begin
        if (st_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:     cmd_o.in_ready = 1'b1;
      S_DISPATCH: begin
        cmd_o.bad = st_i.bad;
        cmd_o.bscan_start = !st_i.bad && (st_i.req_type == REQ_TEST ||
          st_i.req_type == REQ_ADD || st_i.req_type == REQ_DEL ||
          st_i.req_type == REQ_QUERY);
        cmd_o.clear = !st_i.bad && (st_i.req_type == REQ_RST_ALL ||
          st_i.req_type == REQ_RST_CNT || st_i.req_type == REQ_RST_BLK);
      end
      S_BSCAN: begin
        cmd_o.bscan = 1'b1;
        cmd_o.tscan_start = st_i.bscan_done && (st_i.req_type == REQ_TEST);
      end
      S_BACT:  cmd_o.bact = 1'b1;
      S_TSCAN: cmd_o.tscan = 1'b1;
      S_TROW:  cmd_o.trow = 1'b1;
      S_TEVAL: cmd_o.teval = 1'b1;
      S_SUM:   cmd_o.sum = 1'b1;
      S_CHECK: cmd_o.check = 1'b1;
      S_TICK: begin
        cmd_o.tick_adv = 1'b1;
        cmd_o.tscan_start = 1'b1;
      end
      S_RESP:  cmd_o.load_out = st_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- hdl/abrl_dp.sv -----
// Datapath: configuration, blocklist and tracking memories, window sums and result register.
module abrl_dp import abrl_pkg::*; #(
  parameter int TRACK_ENTRIES = 256,
  parameter int BLOCK_ENTRIES = 64,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LIM_W-1:0]     cfg_data_i,
  input  logic                 req_valid_i,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [ADDR_W-1:0]    req_addr_i,
  input  logic                 rsp_ready_i,
  output logic                 rsp_valid_o,
  output logic                 allowed_o,
  output logic [STAT_W-1:0]    status_o,
  output logic                 listed_o,
  output logic [SIZE_W-1:0]    size_o,
  output logic [LIM_W-1:0]     hit_o,
  input  cmd_t                 cmd_i,
  output status_t              st_o
);

  localparam int TW   = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
  localparam int BW   = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int BCW  = $clog2(BLOCK_ENTRIES + 1);
  localparam int SW   = COUNT_WIDTH + 4;
  localparam int CMPW = (SW > LIM_W) ? SW : LIM_W;
  localparam logic [TW-1:0] T_LAST = TW'(TRACK_ENTRIES - 1);
  localparam logic [BW-1:0] B_LAST = BW'(BLOCK_ENTRIES - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef logic [NUM_SLOTS-1:0][COUNT_WIDTH-1:0] row_t;

  logic             blk_en_q, lim_en_q;
  logic [LIM_W-1:0] lim1_q, lim5_q, lim15_q, lim60_q;

  req_e              req_type_q;
  logic [ADDR_W-1:0] addr_q;

  logic [ADDR_W-1:0]        blk_mem [BLOCK_ENTRIES];
  logic [ADDR_W-1:0]        blk_rd_q;
  logic [BLOCK_ENTRIES-1:0] blk_valid_q;
  logic [BCW-1:0]           blk_cnt_q;
  logic [BW-1:0]            bidx_q, bpidx_q, bhit_q, bfree_q;
  logic                     bissue_q, bpend_q, bfound_q, bfree_found_q;

  logic [ADDR_W-1:0]        trk_mem [TRACK_ENTRIES];
  logic [ADDR_W-1:0]        trk_rd_q;
  row_t                     cnt_mem [TRACK_ENTRIES];
  row_t                     cnt_rd_q;
  logic [TRACK_ENTRIES-1:0] trk_valid_q;
  logic [TW-1:0]            tidx_q, tpidx_q, thit_q, tfree_q;
  logic                     tissue_q, tpend_q, tfound_q, tfree_found_q;

  logic [2:0] ms_q;
  logic [3:0] fs_q;
  logic       wrap_q;

  row_t                   row_q;
  logic [COUNT_WIDTH-1:0] h1_q;
  logic [SW-1:0]          h5_q, h15_q, h60_q;
  logic [3:0]             sidx_q;

  logic             res_allowed_q, res_listed_q;
  stat_e            res_status_q;
  logic [LIM_W-1:0] res_hit_q;

  logic             out_valid_q, out_allowed_q, out_listed_q;
  logic [STAT_W-1:0] out_status_q;
  logic [SIZE_W-1:0] out_size_q;
  logic [LIM_W-1:0]  out_hit_q;

  logic                  accept, bad, tick_mode, out_free, counting;
  logic                  b_match, b_free, t_match, t_free, tick_wr;
  logic [SLOT_IDX_W-1:0] mi, fi, smi, sfi;
  logic [4:0]            qd, qm;
  logic [TW-1:0]         tsel;
  row_t                  cur_row, bumped, tick_row;
  logic [LIM_W-1:0]      hit_cur;
  logic                  cnt_we;
  logic [TW-1:0]         cnt_waddr;
  row_t                  cnt_wdata;

  function automatic logic [LIM_W-1:0] sat_hit(input logic [CMPW-1:0] v);
    return (v > CMPW'(HIT_MAX)) ? HIT_MAX : v[LIM_W-1:0];
  endfunction

  assign accept    = req_valid_i && cmd_i.in_ready;
  assign bad       = (req_type_q == REQ_TEST || req_type_q == REQ_ADD ||
                      req_type_q == REQ_DEL || req_type_q == REQ_QUERY) &&
                     (addr_q[ADDR_W-1:1] == '0);
  assign tick_mode = (req_type_q == REQ_TICK);
  assign out_free  = !out_valid_q || rsp_ready_i;
  assign counting  = !blk_en_q && lim_en_q && (tfound_q || tfree_found_q);

  assign b_match = bpend_q && blk_valid_q[bpidx_q] && (blk_rd_q == addr_q);
  assign b_free  = bpend_q && !blk_valid_q[bpidx_q];
  assign t_match = tpend_q && trk_valid_q[tpidx_q] && (trk_rd_q == addr_q);
  assign t_free  = tpend_q && !trk_valid_q[tpidx_q];
  assign tsel    = tfound_q ? thit_q : tfree_q;

  assign mi  = SLOT_IDX_W'(ms_q);
  assign fi  = SLOT_IDX_W'(MIN_SLOTS) + SLOT_IDX_W'(fs_q);
  assign smi = SLOT_IDX_W'(sidx_q);
  assign sfi = SLOT_IDX_W'(MIN_SLOTS) + SLOT_IDX_W'(sidx_q);
  assign qd  = 5'(fs_q) + 5'(FIVE_SLOTS) - 5'(sidx_q);
  assign qm  = (qd >= 5'(FIVE_SLOTS)) ? qd - 5'(FIVE_SLOTS) : qd;

  always_comb begin
    cur_row = tfound_q ? cnt_rd_q : '0;
    hit_cur = tfound_q ? sat_hit(CMPW'(cnt_rd_q[mi])) : '0;
    bumped  = cur_row;
    if (bumped[mi] != CNT_MAX) bumped[mi] = bumped[mi] + 1'b1;
    if (bumped[fi] != CNT_MAX) bumped[fi] = bumped[fi] + 1'b1;
    tick_row = cnt_rd_q;
    tick_row[mi] = '0;
    if (wrap_q) tick_row[fi] = '0;
  end

  assign tick_wr   = cmd_i.tscan && tick_mode && tpend_q && trk_valid_q[tpidx_q];
  assign cnt_we    = (cmd_i.teval && counting) || tick_wr;
  assign cnt_waddr = cmd_i.teval ? tsel : tpidx_q;
  assign cnt_wdata = cmd_i.teval ? bumped : tick_row;

  always_ff @(posedge clk_i) begin
    if (cmd_i.bact && req_type_q == REQ_ADD && !bfound_q && bfree_found_q) begin
      blk_mem[bfree_q] <= addr_q;
    end
    if (cmd_i.bscan && bissue_q) blk_rd_q <= blk_mem[bidx_q];
    if (cmd_i.teval && counting && !tfound_q) trk_mem[tfree_q] <= addr_q;
    if (cmd_i.tscan && tissue_q) trk_rd_q <= trk_mem[tidx_q];
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cmd_i.tscan && tissue_q) begin
      cnt_rd_q <= cnt_mem[tidx_q];
    end else if (cmd_i.trow) begin
      cnt_rd_q <= cnt_mem[thit_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_en_q <= 1'b0;
      lim_en_q <= 1'b0;
      lim1_q   <= '0;
      lim5_q   <= '0;
      lim15_q  <= '0;
      lim60_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_BLK_EN: blk_en_q <= cfg_data_i[0];
        CFG_LIM_EN: lim_en_q <= cfg_data_i[0];
        CFG_LIM1:   lim1_q   <= cfg_data_i;
        CFG_LIM5:   lim5_q   <= cfg_data_i;
        CFG_LIM15:  lim15_q  <= cfg_data_i;
        CFG_LIM60:  lim60_q  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_type_q    <= REQ_TEST;
      blk_valid_q   <= '0;
      blk_cnt_q     <= '0;
      bidx_q        <= '0;
      bpidx_q       <= '0;
      bhit_q        <= '0;
      bfree_q       <= '0;
      bissue_q      <= 1'b0;
      bpend_q       <= 1'b0;
      bfound_q      <= 1'b0;
      bfree_found_q <= 1'b0;
      trk_valid_q   <= '0;
      tidx_q        <= '0;
      tpidx_q       <= '0;
      thit_q        <= '0;
      tfree_q       <= '0;
      tissue_q      <= 1'b0;
      tpend_q       <= 1'b0;
      tfound_q      <= 1'b0;
      tfree_found_q <= 1'b0;
      ms_q          <= '0;
      fs_q          <= '0;
      wrap_q        <= 1'b0;
      sidx_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) req_type_q <= req_e'(req_type_i);

      if (cmd_i.bscan_start) begin
        bidx_q        <= '0;
        bissue_q      <= 1'b1;
        bpend_q       <= 1'b0;
        bfound_q      <= 1'b0;
        bfree_found_q <= 1'b0;
      end else if (cmd_i.bscan) begin
        bpend_q <= bissue_q;
        bpidx_q <= bidx_q;
        if (bissue_q) begin
          if (bidx_q == B_LAST) bissue_q <= 1'b0;
          else bidx_q <= bidx_q + 1'b1;
        end
        if (b_match && !bfound_q) begin
          bfound_q <= 1'b1;
          bhit_q   <= bpidx_q;
        end
        if (b_free && !bfree_found_q) begin
          bfree_found_q <= 1'b1;
          bfree_q       <= bpidx_q;
        end
      end

      if (cmd_i.tscan_start) begin
        tidx_q        <= '0;
        tissue_q      <= 1'b1;
        tpend_q       <= 1'b0;
        tfound_q      <= 1'b0;
        tfree_found_q <= 1'b0;
      end else if (cmd_i.tscan) begin
        tpend_q <= tissue_q;
        tpidx_q <= tidx_q;
        if (tissue_q) begin
          if (tidx_q == T_LAST) tissue_q <= 1'b0;
          else tidx_q <= tidx_q + 1'b1;
        end
        if (!tick_mode && t_match && !tfound_q) begin
          tfound_q <= 1'b1;
          thit_q   <= tpidx_q;
        end
        if (!tick_mode && t_free && !tfree_found_q) begin
          tfree_found_q <= 1'b1;
          tfree_q       <= tpidx_q;
        end
      end

      if (tick_wr && tick_row == '0) trk_valid_q[tpidx_q] <= 1'b0;
      if (cmd_i.teval && counting && !tfound_q) trk_valid_q[tfree_q] <= 1'b1;

      if (cmd_i.bact && req_type_q == REQ_ADD && !bfound_q && bfree_found_q) begin
        blk_valid_q[bfree_q] <= 1'b1;
        blk_cnt_q            <= blk_cnt_q + 1'b1;
      end
      if (cmd_i.bact && req_type_q == REQ_DEL && bfound_q) begin
        blk_valid_q[bhit_q] <= 1'b0;
        blk_cnt_q           <= blk_cnt_q - 1'b1;
      end

      if (cmd_i.clear) begin
        if (req_type_q == REQ_RST_ALL || req_type_q == REQ_RST_CNT) trk_valid_q <= '0;
        if (req_type_q == REQ_RST_ALL || req_type_q == REQ_RST_BLK) begin
          blk_valid_q <= '0;
          blk_cnt_q   <= '0;
        end
      end

      if (cmd_i.tick_adv) begin
        wrap_q <= (ms_q == 3'(MIN_SLOTS - 1));
        if (ms_q == 3'(MIN_SLOTS - 1)) begin
          ms_q <= '0;
          fs_q <= (fs_q == 4'(FIVE_SLOTS - 1)) ? '0 : fs_q + 1'b1;
        end else begin
          ms_q <= ms_q + 1'b1;
        end
      end

      if (cmd_i.teval) sidx_q <= '0;
      else if (cmd_i.sum) sidx_q <= sidx_q + 1'b1;

      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (rsp_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q        <= req_addr_i;
      res_allowed_q <= 1'b0;
      res_status_q  <= ST_DONE;
      res_listed_q  <= 1'b0;
      res_hit_q     <= '0;
    end
    if (cmd_i.bad) res_status_q <= ST_BAD_ADDR;
    if (cmd_i.bact) begin
      case (req_type_q)
        REQ_ADD: begin
          res_listed_q <= bfound_q || bfree_found_q;
          if (!bfound_q && !bfree_found_q) res_status_q <= ST_FULL;
        end
        REQ_QUERY: res_listed_q <= bfound_q;
        default:   res_listed_q <= 1'b0;
      endcase
    end
    if (cmd_i.teval) begin
      res_listed_q <= bfound_q;
      h1_q         <= bumped[mi];
      row_q        <= bumped;
      h5_q         <= '0;
      h15_q        <= '0;
      h60_q        <= '0;
      if (blk_en_q) begin
        res_allowed_q <= !bfound_q;
        res_status_q  <= bfound_q ? ST_BLOCKED : ST_OK;
        res_hit_q     <= hit_cur;
      end else if (!lim_en_q) begin
        res_allowed_q <= 1'b1;
        res_status_q  <= ST_OK;
        res_hit_q     <= hit_cur;
      end else if (!counting) begin
        res_status_q <= ST_FULL;
        res_hit_q    <= '0;
      end
    end
    if (cmd_i.sum) begin
      h60_q <= h60_q + SW'(row_q[sfi]);
      if (sidx_q < 4'(MIN_SLOTS)) h5_q <= h5_q + SW'(row_q[smi]);
      if (qm < 5'(QUARTER_SLOTS)) h15_q <= h15_q + SW'(row_q[sfi]);
    end
    if (cmd_i.check) begin
      if (lim1_q != '0 && CMPW'(h1_q) > CMPW'(lim1_q)) begin
        res_status_q <= ST_LIM1;
        res_hit_q    <= sat_hit(CMPW'(h1_q));
      end else if (lim5_q != '0 && CMPW'(h5_q) > CMPW'(lim5_q)) begin
        res_status_q <= ST_LIM5;
        res_hit_q    <= sat_hit(CMPW'(h5_q));
      end else if (lim15_q != '0 && CMPW'(h15_q) > CMPW'(lim15_q)) begin
        res_status_q <= ST_LIM15;
        res_hit_q    <= sat_hit(CMPW'(h15_q));
      end else if (lim60_q != '0 && CMPW'(h60_q) > CMPW'(lim60_q)) begin
        res_status_q <= ST_LIM60;
        res_hit_q    <= sat_hit(CMPW'(h60_q));
      end else begin
        res_allowed_q <= 1'b1;
        res_status_q  <= ST_OK;
        res_hit_q     <= sat_hit(CMPW'(h1_q));
      end
    end
    if (cmd_i.load_out) begin
      out_allowed_q <= res_allowed_q;
      out_status_q  <= res_status_q;
      out_listed_q  <= res_listed_q;
      out_size_q    <= SIZE_W'(blk_cnt_q);
      out_hit_q     <= res_hit_q;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign allowed_o   = out_allowed_q;
  assign status_o    = out_status_q;
  assign listed_o    = out_listed_q;
  assign size_o      = out_size_q;
  assign hit_o       = out_hit_q;

  always_comb begin
    st_o            = '0;
    st_o.in_valid   = req_valid_i;
    st_o.req_type   = req_type_q;
    st_o.bad        = bad;
    st_o.bscan_done = bpend_q && !bissue_q;
    st_o.tscan_done = tpend_q && !tissue_q;
    st_o.counting   = counting;
    st_o.sum_done   = (sidx_q == 4'(FIVE_SLOTS - 1));
    st_o.out_free   = out_free;
  end

`ifndef SYNTHESIS
  a_blk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_cnt_q == BCW'($countones(blk_valid_q)))
    else $error("blocklist count does not match valid entries");
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ms_q < 3'(MIN_SLOTS) && fs_q < 4'(FIVE_SLOTS))
    else $error("slot pointer out of range");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> out_free)
    else $error("result loaded over an untaken result");
  a_track_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.teval && counting && !tfound_q) |-> !trk_valid_q[tfree_q])
    else $error("allocated a tracking entry that is in use");
`endif

endmodule

// ----- hdl/address_blocklist_rate_limiter_top.sv -----
// Top level of the address blocklist rate limiter.
// One request is in work at a time; a new one is taken while the previous result waits.
// Flow of a request: a counted test scans the blocklist and then the tracking table,
// each one entry per cycle through its memory read port, then sums the window slots and
// checks the limits. A test that counts nothing skips the sum and the check. Add, delete
// and query scan only the blocklist; a minute tick scans the tracking table and rewrites
// one row per cycle; bad addresses and resets go straight to the result. The next request
// can be taken in the cycle after the result is loaded; a result not yet taken holds the
// request behind it in its response state.
// No clearing pass runs after reset.
module address_blocklist_rate_limiter_top import abrl_pkg::*; #(
  parameter int TRACK_ENTRIES = 256,
  parameter int BLOCK_ENTRIES = 64,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LIM_W-1:0]     cfg_data_i,
  abrl_req_if.sink             req,
  abrl_rsp_if.source           rsp
);

  cmd_t    cmd;
  status_t st;

  abrl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  abrl_dp #(
    .TRACK_ENTRIES (TRACK_ENTRIES),
    .BLOCK_ENTRIES (BLOCK_ENTRIES),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (req.valid),
    .req_type_i  (req.req_type),
    .req_addr_i  (req.source_address),
    .rsp_ready_i (rsp.ready),
    .rsp_valid_o (rsp.valid),
    .allowed_o   (rsp.allowed),
    .status_o    (rsp.status),
    .listed_o    (rsp.listed),
    .size_o      (rsp.blocklist_size),
    .hit_o       (rsp.hit_count),
    .cmd_i       (cmd),
    .st_o        (st)
  );

  assign req.ready = cmd.in_ready;

endmodule
